### sv/glcd_pkg.sv
// Shared types and constants for the glyph to LCD pixel writer.
// Used by the front, queue, back and top-level modules; no dependencies.
`default_nettype none

package glcd_pkg;

    // panel command bytes
    localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
    localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
    localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

    // input item kinds (tuser)
    localparam logic OP_START = 1'b0;
    localparam logic OP_GLYPH = 1'b1;

    // font select codes
    localparam logic [1:0] FONT_6X12  = 2'd0;
    localparam logic [1:0] FONT_8X16  = 2'd1;
    localparam logic [1:0] FONT_12X24 = 2'd2;

    // register map
    localparam int         APB_ADDR_W = 3;
    localparam logic       REG_FG     = 1'b0;
    localparam logic       REG_BG     = 1'b1;
    localparam logic [15:0] FG_RESET  = 16'hFFFF;
    localparam logic [15:0] BG_RESET  = 16'h0000;

    // default screen size
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 480;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // window sequence steps
    localparam logic [3:0] WIN_CASET  = 4'd0;
    localparam logic [3:0] WIN_XS_HI  = 4'd1;
    localparam logic [3:0] WIN_XS_LO  = 4'd2;
    localparam logic [3:0] WIN_XE_HI  = 4'd3;
    localparam logic [3:0] WIN_XE_LO  = 4'd4;
    localparam logic [3:0] WIN_PASET  = 4'd5;
    localparam logic [3:0] WIN_YS_HI  = 4'd6;
    localparam logic [3:0] WIN_YS_LO  = 4'd7;
    localparam logic [3:0] WIN_YE_HI  = 4'd8;
    localparam logic [3:0] WIN_YE_LO  = 4'd9;
    localparam logic [3:0] WIN_RAMWR  = 4'd10;

    typedef enum logic {
        JOB_WINDOW = 1'b0,
        JOB_PIXELS = 1'b1
    } job_kind_t;

    // one unit of work for the back end
    typedef struct packed {
        job_kind_t  kind;
        logic [9:0] x_start;
        logic [9:0] x_end;
        logic [9:0] y_start;
        logic [9:0] y_end;
        logic [7:0] bits;
        logic [3:0] count;      // pixels kept from this byte, 1 to 8
        logic       final_byte;
    } job_t;

endpackage

`default_nettype wire

### sv/glcd_front.sv
// Front end: accepts start and glyph byte items, tracks the glyph state and
// turns each item that yields work into a window or pixel job. Depends on glcd_pkg.
`default_nettype none

module glcd_front #(
    parameter int SCREEN_WIDTH  = glcd_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = glcd_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic           op,
    input  wire logic [9:0]     x_position,
    input  wire logic [9:0]     y_position,
    input  wire logic [1:0]     font_select,
    input  wire logic [7:0]     glyph_byte,
    output glcd_pkg::job_t      job,
    output logic                push
);

    localparam logic [10:0] X_LAST = 11'(SCREEN_WIDTH - 1);
    localparam logic [10:0] Y_LAST = 11'(SCREEN_HEIGHT - 1);

    logic       glyph_active_reg, glyph_active_next;
    logic [3:0] cell_width_reg, cell_width_next;
    logic [5:0] bytes_remaining_reg, bytes_remaining_next;
    logic [3:0] row_pixel_count_reg, row_pixel_count_next;

    logic       font_ok;
    logic [3:0] font_w;
    logic [4:0] font_h;
    logic [5:0] font_bytes;
    logic [10:0] x_end_sum;
    logic [10:0] y_end_sum;
    logic       fits;
    logic [3:0] row_left;
    logic [5:0] bytes_after;

    // font size decode
    always_comb
    begin
        font_ok    = 1'b1;
        font_w     = 4'd6;
        font_h     = 5'd12;
        font_bytes = 6'd12;
        case (font_select)
            glcd_pkg::FONT_6X12:
            begin
                font_w     = 4'd6;
                font_h     = 5'd12;
                font_bytes = 6'd12;
            end
            glcd_pkg::FONT_8X16:
            begin
                font_w     = 4'd8;
                font_h     = 5'd16;
                font_bytes = 6'd16;
            end
            glcd_pkg::FONT_12X24:
            begin
                font_w     = 4'd12;
                font_h     = 5'd24;
                font_bytes = 6'd48;
            end
            default:
            begin
                font_ok = 1'b0;
            end
        endcase
    end

    // cell bounds against the screen
    assign x_end_sum = {1'b0, x_position} + {7'd0, font_w} - 11'd1;
    assign y_end_sum = {1'b0, y_position} + {6'd0, font_h} - 11'd1;
    assign fits      = (x_end_sum <= X_LAST) && (y_end_sum <= Y_LAST);

    assign row_left    = cell_width_reg - row_pixel_count_reg;
    assign bytes_after = bytes_remaining_reg - 6'd1;

    // classify item and build job
    always_comb
    begin
        glyph_active_next    = glyph_active_reg;
        cell_width_next      = cell_width_reg;
        bytes_remaining_next = bytes_remaining_reg;
        row_pixel_count_next = row_pixel_count_reg;
        push                 = 1'b0;
        job                  = '0;
        job.x_start          = x_position;
        job.x_end            = x_end_sum[9:0];
        job.y_start          = y_position;
        job.y_end            = y_end_sum[9:0];
        job.bits             = glyph_byte;
        if (accept)
        begin
            if (op == glcd_pkg::OP_START)
            begin
                glyph_active_next = 1'b0;
                if (font_ok && fits)
                begin
                    push                 = 1'b1;
                    job.kind             = glcd_pkg::JOB_WINDOW;
                    glyph_active_next    = 1'b1;
                    cell_width_next      = font_w;
                    bytes_remaining_next = font_bytes;
                    row_pixel_count_next = 4'd0;
                end
            end
            else if (glyph_active_reg)
            begin
                push                 = 1'b1;
                job.kind             = glcd_pkg::JOB_PIXELS;
                job.final_byte       = (bytes_after == 6'd0);
                bytes_remaining_next = bytes_after;
                if (row_left <= 4'd8)
                begin
                    job.count            = row_left;
                    row_pixel_count_next = 4'd0;
                end
                else
                begin
                    job.count            = 4'd8;
                    row_pixel_count_next = row_pixel_count_reg + 4'd8;
                end
                if (bytes_after == 6'd0)
                begin
                    glyph_active_next = 1'b0;
                end
            end
        end
    end

    // glyph state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_active_reg    <= 1'b0;
            cell_width_reg      <= 4'd0;
            bytes_remaining_reg <= 6'd0;
            row_pixel_count_reg <= 4'd0;
        end
        else
        begin
            glyph_active_reg    <= glyph_active_next;
            cell_width_reg      <= cell_width_next;
            bytes_remaining_reg <= bytes_remaining_next;
            row_pixel_count_reg <= row_pixel_count_next;
        end
    end

endmodule

`default_nettype wire

### sv/glcd_queue.sv
// Short job queue between the front and back ends.
// Depends on glcd_pkg for the job type and default depth.
`default_nettype none

module glcd_queue #(
    parameter int DEPTH = glcd_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire glcd_pkg::job_t  push_job,
    input  wire logic            pop,
    output glcd_pkg::job_t       head_job,
    output logic                 not_empty,
    output logic                 full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    glcd_pkg::job_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = mem[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

### sv/glcd_back.sv
// Back end: steps through the current job one bus write per cycle unless
// out_ready stalls it, and holds each write in an output register. Depends on glcd_pkg.
`default_nettype none

module glcd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire glcd_pkg::job_t  head_job,
    input  wire logic            head_valid,
    output logic                 pop,
    input  wire logic [15:0]     foreground_color,
    input  wire logic [15:0]     background_color,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 is_command,
    output logic [15:0]          bus_word,
    output logic                 last,
    output logic                 glyph_done
);

    glcd_pkg::job_t cur_job_reg, cur_job_next;
    logic           cur_valid_reg, cur_valid_next;
    logic [3:0]     step_reg, step_next;

    logic           out_valid_reg, out_valid_next;
    logic           is_command_reg;
    logic [15:0]    bus_word_reg;
    logic           last_reg;
    logic           glyph_done_reg;

    logic           advance;
    logic           last_step;
    logic           w_cmd;
    logic [15:0]    w_word;
    logic           w_last;
    logic           w_done;
    logic           pixel_bit;

    assign advance   = cur_valid_reg && (!out_valid_reg || out_ready);
    assign last_step = (cur_job_reg.kind == glcd_pkg::JOB_WINDOW)
                       ? (step_reg == glcd_pkg::WIN_RAMWR)
                       : (step_reg == cur_job_reg.count - 4'd1);
    assign pop       = head_valid && (!cur_valid_reg || (advance && last_step));
    assign pixel_bit = cur_job_reg.bits[~step_reg[2:0]];

    // write word for the current step
    always_comb
    begin
        w_cmd  = 1'b0;
        w_word = 16'd0;
        w_last = 1'b0;
        w_done = 1'b0;
        if (cur_job_reg.kind == glcd_pkg::JOB_PIXELS)
        begin
            w_word = pixel_bit ? foreground_color : background_color;
            w_last = last_step;
            w_done = last_step && cur_job_reg.final_byte;
        end
        else
        begin
            case (step_reg)
                glcd_pkg::WIN_CASET:
                begin
                    w_cmd  = 1'b1;
                    w_word = {8'd0, glcd_pkg::CMD_COL_ADDR};
                end
                glcd_pkg::WIN_XS_HI: w_word = {14'd0, cur_job_reg.x_start[9:8]};
                glcd_pkg::WIN_XS_LO: w_word = {8'd0, cur_job_reg.x_start[7:0]};
                glcd_pkg::WIN_XE_HI: w_word = {14'd0, cur_job_reg.x_end[9:8]};
                glcd_pkg::WIN_XE_LO: w_word = {8'd0, cur_job_reg.x_end[7:0]};
                glcd_pkg::WIN_PASET:
                begin
                    w_cmd  = 1'b1;
                    w_word = {8'd0, glcd_pkg::CMD_ROW_ADDR};
                end
                glcd_pkg::WIN_YS_HI: w_word = {14'd0, cur_job_reg.y_start[9:8]};
                glcd_pkg::WIN_YS_LO: w_word = {8'd0, cur_job_reg.y_start[7:0]};
                glcd_pkg::WIN_YE_HI: w_word = {14'd0, cur_job_reg.y_end[9:8]};
                glcd_pkg::WIN_YE_LO: w_word = {8'd0, cur_job_reg.y_end[7:0]};
                glcd_pkg::WIN_RAMWR:
                begin
                    w_cmd  = 1'b1;
                    w_word = {8'd0, glcd_pkg::CMD_MEM_WR};
                    w_last = 1'b1;
                end
                default:
                begin
                    w_word = 16'd0;
                end
            endcase
        end
    end

    // current job and step counter
    always_comb
    begin
        cur_job_next   = cur_job_reg;
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (advance)
        begin
            step_next = step_reg + 4'd1;
        end
        if (advance && last_step)
        begin
            cur_valid_next = 1'b0;
        end
        if (pop)
        begin
            cur_job_next   = head_job;
            cur_valid_next = 1'b1;
            step_next      = 4'd0;
        end
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_job_reg <= cur_job_next;
        if (advance)
        begin
            is_command_reg <= w_cmd;
            bus_word_reg   <= w_word;
            last_reg       <= w_last;
            glyph_done_reg <= w_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_command = is_command_reg;
    assign bus_word   = bus_word_reg;
    assign last       = last_reg;
    assign glyph_done = glyph_done_reg;

endmodule

`default_nettype wire

### sv/glyph_to_lcd_pixel_writer.sv
// Top level of the glyph to LCD pixel writer: color registers on an APB
// port, front end, job queue and back end. Depends on glcd_pkg and submodules.
//
//   channel   direction  handshake          payload
//   s_*       in         s_tvalid/s_tready  tuser: op; tdata: x, y, font, glyph
//   m_*       out        m_tvalid/m_tready  tuser: is_command, glyph_done;
//                                           tdata: bus_word; tlast: last
//   apb       in         psel/penable       foreground/background color
//
// A start item gives 11 bus writes, a glyph byte 1 to 8; items that give
// no write are still accepted. The back end's single output register sets
// the pace at one bus write per cycle while m_tready holds high.
// Input is taken every cycle while the two-entry job queue has room.
// Reset clears glyph state, queue and output valid; colors reset to white/black.
`default_nettype none

module glyph_to_lcd_pixel_writer #(
    parameter int SCREEN_WIDTH  = glcd_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = glcd_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [31:0]                     s_tdata,  // x[9:0] y[19:10] font[21:20] glyph[29:22]
    input  wire logic                            s_tuser,  // op
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [15:0]                          m_tdata,  // bus_word
    output logic [1:0]                           m_tuser,  // is_command, glyph_done
    output logic                                 m_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [glcd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic [15:0]    fg_color_reg;
    logic [15:0]    bg_color_reg;
    logic           cfg_write;

    logic           s_accept;
    logic           q_push;
    glcd_pkg::job_t q_push_job;
    logic           q_pop;
    glcd_pkg::job_t q_head_job;
    logic           q_not_empty;
    logic           q_full;

    logic           out_cmd;
    logic           out_done;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = {16'd0, (paddr[2] == glcd_pkg::REG_BG) ? bg_color_reg : fg_color_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg <= glcd_pkg::FG_RESET;
            bg_color_reg <= glcd_pkg::BG_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == glcd_pkg::REG_FG)
            begin
                fg_color_reg <= pwdata[15:0];
            end
            else
            begin
                bg_color_reg <= pwdata[15:0];
            end
        end
    end

    // input handshake
    assign s_tready = !q_full;
    assign s_accept = s_tvalid && s_tready;

    glcd_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (s_accept),
        .op          (s_tuser),
        .x_position  (s_tdata[9:0]),
        .y_position  (s_tdata[19:10]),
        .font_select (s_tdata[21:20]),
        .glyph_byte  (s_tdata[29:22]),
        .job         (q_push_job),
        .push        (q_push)
    );

    glcd_queue #(
        .DEPTH (glcd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_push_job),
        .pop       (q_pop),
        .head_job  (q_head_job),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    glcd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_job         (q_head_job),
        .head_valid       (q_not_empty),
        .pop              (q_pop),
        .foreground_color (fg_color_reg),
        .background_color (bg_color_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .is_command       (out_cmd),
        .bus_word         (m_tdata),
        .last             (m_tlast),
        .glyph_done       (out_done)
    );

    assign m_tuser = {out_done, out_cmd};

    // end of character is always the last write of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
        else $error("glyph_done without last or on a command");

    // commands are only the three window opcodes
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == 16'h002A) || (m_tdata == 16'h002B)
                                   || (m_tdata == 16'h002C))
        else $error("unexpected command word");

    // memory write command closes the window sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] && (m_tdata == 16'h002C) |-> m_tlast)
        else $error("memory write command without last");

    // the front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

endmodule

`default_nettype wire
